>>> rtl/slqf_pkg.sv
package slqf_pkg;

  localparam int OUTPUT_COUNT = 8;
  localparam int OUT_W       = 3;
  localparam int PORT_W      = 3;
  localparam int FIELD_LEN_W = 16;
  localparam int LEN_MAX_W   = 32;
  localparam int CFG_W       = 4;

  localparam logic [CFG_W-1:0] ACTIVE_OUTPUTS_RESET = 4'd8;

  typedef struct packed {
    logic [PORT_W-1:0]      port_index;
    logic                   first_of_slot;
    logic [FIELD_LEN_W-1:0] len_0;
    logic [FIELD_LEN_W-1:0] len_1;
    logic [FIELD_LEN_W-1:0] len_2;
    logic [FIELD_LEN_W-1:0] len_3;
    logic [FIELD_LEN_W-1:0] len_4;
    logic [FIELD_LEN_W-1:0] len_5;
    logic [FIELD_LEN_W-1:0] len_6;
    logic [FIELD_LEN_W-1:0] len_7;
  } in_item_t;

  typedef struct packed {
    logic [PORT_W-1:0] echo_port;
    logic [OUT_W-1:0]  proposed_output;
    logic              granted;
    logic              displaced_valid;
    logic [PORT_W-1:0] displaced_port;
  } out_item_t;

endpackage

>>> rtl/slqf_in_if.sv
interface slqf_in_if import slqf_pkg::*; ();

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

>>> rtl/slqf_out_if.sv
interface slqf_out_if import slqf_pkg::*; ();

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

>>> rtl/serial_longest_queue_first_matcher.sv
// Longest-queue-first crossbar matcher for an input-queued switch.
// Each transfer on in_i carries one input port's virtual output queue
// lengths. The port proposes its longest queue among the first
// active_outputs outputs (lowest index on ties) and wins that output if its
// port is below NUM_PORTS and the output is free or held by a shorter queue.
// One transfer on out_o follows per input transfer, in order, reporting the
// proposal, the grant and any displaced holder. Setting first_of_slot frees
// every output before that item is judged.
// An item sits in the input register, and the argmax tree plus holder compare
// then write the result register.
// Throughput is one item per cycle while out_o accepts results, bounded by
// the single holder table, which is read and updated in the same cycle as the compare.
// When out_o stalls, the result register holds its item and the input
// register can still take one more; ready on in_i drops only when both
// are full and out_o is not ready.
// The user must write active_outputs via cfg_we_i/cfg_wdata_i only while
// idle; the block does not enforce it. Reset empties both registers, frees
// all outputs and sets active_outputs to eight.
module serial_longest_queue_first_matcher import slqf_pkg::*; #(
  parameter int NUM_PORTS = 8,
  parameter int LEN_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  slqf_in_if.sink          in_i,
  slqf_out_if.source       out_o
);

  logic [CFG_W-1:0] active_outputs_q;

  logic      s1_valid_q;
  in_item_t  s1_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res_d;

  logic [OUTPUT_COUNT-1:0] taken_q, taken_d;
  logic [PORT_W-1:0]       holder_port_q [OUTPUT_COUNT];
  logic [LEN_WIDTH-1:0]    holder_len_q  [OUTPUT_COUNT];

  logic [OUTPUT_COUNT-1:0][FIELD_LEN_W-1:0] lens_raw;
  logic [OUTPUT_COUNT-1:0][LEN_WIDTH-1:0]   lens;
  logic [LEN_MAX_W-1:0]                     len_wide [OUTPUT_COUNT];
  logic [OUT_W-1:0]                         best;
  logic [LEN_WIDTH-1:0]                     best_len;

  logic out_adv;
  logic fire;
  logic port_ok;
  logic best_taken;
  logic win;

  assign out_adv    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || out_adv;
  assign fire       = s1_valid_q && out_adv;

  assign lens_raw = {s1_q.len_7, s1_q.len_6, s1_q.len_5, s1_q.len_4,
                     s1_q.len_3, s1_q.len_2, s1_q.len_1, s1_q.len_0};

  always_comb begin
    for (int k = 0; k < OUTPUT_COUNT; k++) begin
      len_wide[k] = LEN_MAX_W'(lens_raw[k]);
      lens[k]     = len_wide[k][LEN_WIDTH-1:0];
    end
  end

  slqf_select #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_select (
    .active_outputs_i(active_outputs_q),
    .lens_i          (lens),
    .best_o          (best),
    .best_len_o      (best_len)
  );

  // A first-of-slot item sees every output as free.
  assign port_ok    = (LEN_MAX_W'(s1_q.port_index) < LEN_MAX_W'(NUM_PORTS));
  assign best_taken = taken_q[best] && !s1_q.first_of_slot;
  assign win        = port_ok && (!best_taken || (best_len > holder_len_q[best]));

  always_comb begin
    res_d.echo_port       = s1_q.port_index;
    res_d.proposed_output = best;
    res_d.granted         = win;
    res_d.displaced_valid = win && best_taken;
    res_d.displaced_port  = (win && best_taken) ? holder_port_q[best] : '0;

    taken_d = taken_q;
    if (fire) begin
      if (s1_q.first_of_slot) begin
        taken_d = '0;
      end
      if (win) begin
        taken_d[best] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_outputs_q <= ACTIVE_OUTPUTS_RESET;
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      taken_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        active_outputs_q <= cfg_wdata_i;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
      taken_q <= taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_i.data;
    end
    if (fire) begin
      out_q <= res_d;
    end
    if (fire && win) begin
      holder_port_q[best] <= s1_q.port_index;
      holder_len_q[best]  <= best_len;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

>>> rtl/slqf_select.sv
module slqf_select import slqf_pkg::*; #(
  parameter int LEN_WIDTH = 16
) (
  input  logic [CFG_W-1:0]                         active_outputs_i,
  input  logic [OUTPUT_COUNT-1:0][LEN_WIDTH-1:0]   lens_i,
  output logic [OUT_W-1:0]                         best_o,
  output logic [LEN_WIDTH-1:0]                     best_len_o
);

  typedef struct packed {
    logic                 vld;
    logic [OUT_W-1:0]     idx;
    logic [LEN_WIDTH-1:0] len;
  } cand_t;

  cand_t lvl0 [OUTPUT_COUNT];
  cand_t lvl1 [OUTPUT_COUNT/2];
  cand_t lvl2 [OUTPUT_COUNT/4];
  cand_t top;

  // The right-hand candidate wins only when strictly longer, so ties stay
  // with the lower output index.
  function automatic cand_t pick(cand_t a, cand_t b);
    if (b.vld && (!a.vld || (b.len > a.len))) begin
      return b;
    end
    return a;
  endfunction

  always_comb begin
    for (int k = 0; k < OUTPUT_COUNT; k++) begin
      lvl0[k].vld = (k == 0) || (CFG_W'(k) < active_outputs_i);
      lvl0[k].idx = OUT_W'(k);
      lvl0[k].len = lens_i[k];
    end
    for (int k = 0; k < OUTPUT_COUNT/2; k++) begin
      lvl1[k] = pick(lvl0[2*k], lvl0[2*k+1]);
    end
    for (int k = 0; k < OUTPUT_COUNT/4; k++) begin
      lvl2[k] = pick(lvl1[2*k], lvl1[2*k+1]);
    end
    top = pick(lvl2[0], lvl2[1]);
  end

  assign best_o     = top.idx;
  assign best_len_o = top.len;

endmodule

>>> rtl/slqf_checker.sv
module slqf_checker import slqf_pkg::*; #(
  parameter int NUM_PORTS = 8
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // A result waiting on a stalled receiver stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // A holder can only be displaced by a grant.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.displaced_valid |-> out_data_i.granted)
    else $error("displacement without grant");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.displaced_valid |-> out_data_i.displaced_port == '0)
    else $error("displaced port set without displacement");

  // A port outside the switch never wins an output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (32'(out_data_i.echo_port) >= NUM_PORTS) |-> !out_data_i.granted)
    else $error("grant to a port outside the switch");

endmodule

bind serial_longest_queue_first_matcher slqf_checker #(
  .NUM_PORTS(NUM_PORTS)
) u_slqf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
